[src/aabb_pkg.sv]
// Shared constants for the box intersection and difference core.
// No dependencies; used by aabb_intersect_difference_core.
`default_nettype none

package aabb_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam int TOL_BITS     = 31;
    localparam int CFG_DATA_BITS = TOL_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE = 2'd0,
        CFG_TOL  = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        MODE_INTERSECT = 1'b0,
        MODE_DIFF      = 1'b1
    } t_mode;

endpackage

`default_nettype wire

[src/aabb_intersect_difference_core.sv]
// Axis-aligned 3D box intersection / difference core, five-stage pipeline.
// Depends on aabb_pkg for configuration codes and register widths.
//
//  Channel   Dir  Handshake                    Payload
//  --------  ---  ---------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  box A and box B corners
//  m_axis    out  m_axis_tvalid/m_axis_tready  result box, empty flag in tuser
//  cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One item per cycle is accepted while the output is not stalled; each result passes
// through the chain compare -> span subtract -> length-mismatch subtract ->
// tolerance compare and trim -> min/max ordering, one register stage each.
// All stages advance together; a stalled output freezes the whole pipeline and
// s_axis_tready follows that freeze, so nothing is dropped or repeated.
// Reset clears the stage valid bits and both configuration registers.
`default_nettype none

module aabb_intersect_difference_core #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // a_x_lo, a_y_lo, a_z_lo, a_x_hi, a_y_hi, a_z_hi,
    // b_x_lo, b_y_lo, b_z_lo, b_x_hi, b_y_hi, b_z_hi (lowest first), zero padded
    input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // r_x_lo, r_y_lo, r_z_lo, r_x_hi, r_y_hi, r_z_hi (lowest first), zero padded
    output logic [((6*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // empty_res
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [aabb_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [aabb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CB      = COORD_BITS;
    // Differences of differences plus the tolerance need a few guard bits.
    localparam int WB      = ((CB > aabb_pkg::TOL_BITS) ? CB : aabb_pkg::TOL_BITS) + 3;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic                          r_mode;
    logic [aabb_pkg::TOL_BITS-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= aabb_pkg::MODE_INTERSECT;
            r_tol  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == aabb_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_idx == aabb_pkg::CFG_TOL) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    logic signed [WB-1:0] tol_w;
    logic signed [WB-1:0] tol_neg;
    assign tol_w   = WB'($signed({1'b0, r_tol}));
    assign tol_neg = -tol_w;

    // Pipeline advance: every stage moves when the output register can take.
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: per-axis interval tests
    // ------------------------------------------------------------------
    logic signed [CB-1:0] in_a_lo [3];
    logic signed [CB-1:0] in_a_hi [3];
    logic signed [CB-1:0] in_b_lo [3];
    logic signed [CB-1:0] in_b_hi [3];
    logic signed [CB-1:0] n1_s_lo [3];
    logic signed [CB-1:0] n1_s_hi [3];
    logic [2:0]           n1_ov;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_a_lo[k] = $signed(s_axis_tdata[k*CB +: CB]);
            in_a_hi[k] = $signed(s_axis_tdata[(3+k)*CB +: CB]);
            in_b_lo[k] = $signed(s_axis_tdata[(6+k)*CB +: CB]);
            in_b_hi[k] = $signed(s_axis_tdata[(9+k)*CB +: CB]);
            n1_s_lo[k] = in_b_lo[k];
            n1_s_hi[k] = in_b_hi[k];
            n1_ov[k]   = 1'b0;
            // Ordered cases; touching intervals fall into the first two.
            if (in_b_lo[k] <= in_a_lo[k] && in_b_hi[k] <= in_a_lo[k]) begin
                n1_ov[k] = 1'b0;
            end else if (in_a_hi[k] <= in_b_lo[k] && in_a_hi[k] <= in_b_hi[k]) begin
                n1_ov[k] = 1'b0;
            end else if (in_a_lo[k] <= in_b_lo[k] && in_b_hi[k] <= in_a_hi[k]) begin
                n1_ov[k] = 1'b1;
            end else if (in_b_lo[k] <= in_a_lo[k] && in_a_hi[k] <= in_b_hi[k]) begin
                n1_ov[k]   = 1'b1;
                n1_s_lo[k] = in_a_lo[k];
                n1_s_hi[k] = in_a_hi[k];
            end else if (in_a_lo[k] <= in_b_lo[k] && in_a_hi[k] <= in_b_hi[k]) begin
                n1_ov[k]   = 1'b1;
                n1_s_hi[k] = in_a_hi[k];
            end else if (in_b_lo[k] <= in_a_lo[k] && in_b_hi[k] <= in_a_hi[k]) begin
                n1_ov[k]   = 1'b1;
                n1_s_lo[k] = in_a_lo[k];
            end
        end
    end

    logic                 r1_valid;
    logic                 r1_hit;
    logic signed [CB-1:0] r1_a_lo [3];
    logic signed [CB-1:0] r1_a_hi [3];
    logic signed [CB-1:0] r1_s_lo [3];
    logic signed [CB-1:0] r1_s_hi [3];

    // ------------------------------------------------------------------
    // Stage 2: span lengths and edge distances
    // ------------------------------------------------------------------
    logic                 r2_valid;
    logic                 r2_hit;
    logic signed [CB-1:0] r2_a_lo [3];
    logic signed [CB-1:0] r2_a_hi [3];
    logic signed [CB-1:0] r2_s_lo [3];
    logic signed [CB-1:0] r2_s_hi [3];
    logic signed [WB-1:0] r2_di   [3];
    logic signed [WB-1:0] r2_da   [3];
    logic signed [WB-1:0] r2_dlo  [3];
    logic signed [WB-1:0] r2_dhi  [3];
    logic [2:0]           r2_lt_lo;
    logic [2:0]           r2_lt_hi;

    // ------------------------------------------------------------------
    // Stage 3: length mismatch and split test
    // ------------------------------------------------------------------
    logic                 r3_valid;
    logic                 r3_hit;
    logic signed [CB-1:0] r3_a_lo [3];
    logic signed [CB-1:0] r3_a_hi [3];
    logic signed [CB-1:0] r3_s_lo [3];
    logic signed [CB-1:0] r3_s_hi [3];
    logic signed [WB-1:0] r3_d    [3];
    logic [2:0]           r3_split;
    logic [2:0]           r3_lt_lo;
    logic [2:0]           r3_lt_hi;

    // ------------------------------------------------------------------
    // Stage 4: full-overlap test, trim and result selection
    // ------------------------------------------------------------------
    logic                 r4_valid;
    logic                 r4_empty;
    logic                 r4_sort;
    logic signed [CB-1:0] r4_lo [3];
    logic signed [CB-1:0] r4_hi [3];

    logic [2:0]           n4_full;
    logic [2:0]           n4_trim_en;
    logic signed [CB-1:0] n4_lo [3];
    logic signed [CB-1:0] n4_hi [3];
    logic                 n4_empty;
    logic                 n4_sort;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_full[k] = (tol_neg <= r3_d[k]) && (r3_d[k] <= tol_w);
        end
        n4_trim_en[0] = n4_full[1] && n4_full[2];
        n4_trim_en[1] = n4_full[0] && n4_full[2];
        n4_trim_en[2] = n4_full[0] && n4_full[1];

        n4_empty = 1'b0;
        n4_sort  = 1'b1;
        for (int k = 0; k < 3; k++) begin
            n4_lo[k] = r3_a_lo[k];
            n4_hi[k] = r3_a_hi[k];
        end

        if (r_mode == aabb_pkg::MODE_INTERSECT) begin
            for (int k = 0; k < 3; k++) begin
                n4_lo[k] = r3_hit ? r3_s_lo[k] : '0;
                n4_hi[k] = r3_hit ? r3_s_hi[k] : '0;
            end
            n4_empty = !r3_hit;
        end else if (!r3_hit) begin
            // Disjoint boxes return A exactly as given, corners unordered.
            n4_sort = 1'b0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (n4_trim_en[k] && !r3_split[k]) begin
                    if (r3_lt_lo[k]) begin
                        n4_hi[k] = r3_s_lo[k];
                    end else if (r3_lt_hi[k]) begin
                        n4_lo[k] = r3_s_hi[k];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: corner ordering into the output register
    // ------------------------------------------------------------------
    logic                 r5_valid;
    logic                 r5_empty;
    logic                 r5_sort;
    logic signed [CB-1:0] r5_lo [3];
    logic signed [CB-1:0] r5_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= s_axis_tvalid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_hit <= &n1_ov;
            r2_hit <= r1_hit;
            r3_hit <= r2_hit;
            for (int k = 0; k < 3; k++) begin
                r1_a_lo[k] <= in_a_lo[k];
                r1_a_hi[k] <= in_a_hi[k];
                r1_s_lo[k] <= n1_s_lo[k];
                r1_s_hi[k] <= n1_s_hi[k];

                r2_a_lo[k]  <= r1_a_lo[k];
                r2_a_hi[k]  <= r1_a_hi[k];
                r2_s_lo[k]  <= r1_s_lo[k];
                r2_s_hi[k]  <= r1_s_hi[k];
                r2_di[k]    <= WB'(r1_s_hi[k]) - WB'(r1_s_lo[k]);
                r2_da[k]    <= WB'(r1_a_hi[k]) - WB'(r1_a_lo[k]);
                r2_dlo[k]   <= WB'(r1_s_lo[k]) - WB'(r1_a_lo[k]);
                r2_dhi[k]   <= WB'(r1_a_hi[k]) - WB'(r1_s_hi[k]);
                r2_lt_lo[k] <= r1_a_lo[k] < r1_s_lo[k];
                r2_lt_hi[k] <= r1_s_hi[k] < r1_a_hi[k];

                r3_a_lo[k]  <= r2_a_lo[k];
                r3_a_hi[k]  <= r2_a_hi[k];
                r3_s_lo[k]  <= r2_s_lo[k];
                r3_s_hi[k]  <= r2_s_hi[k];
                r3_d[k]     <= r2_di[k] - r2_da[k];
                r3_split[k] <= (r2_dlo[k] > tol_w) && (r2_dhi[k] > tol_w);
                r3_lt_lo[k] <= r2_lt_lo[k];
                r3_lt_hi[k] <= r2_lt_hi[k];

                r4_lo[k] <= n4_lo[k];
                r4_hi[k] <= n4_hi[k];

                if (r4_sort && (r4_hi[k] < r4_lo[k])) begin
                    r5_lo[k] <= r4_hi[k];
                    r5_hi[k] <= r4_lo[k];
                end else begin
                    r5_lo[k] <= r4_lo[k];
                    r5_hi[k] <= r4_hi[k];
                end
            end
            r4_empty <= n4_empty;
            r4_sort  <= n4_sort;
            r5_empty <= r4_empty;
            r5_sort  <= r4_sort;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 3; k++) begin
            m_axis_tdata[k*CB +: CB]     = r5_lo[k];
            m_axis_tdata[(3+k)*CB +: CB] = r5_hi[k];
        end
    end

    assign m_axis_tuser  = r5_empty;
    assign m_axis_tvalid = r5_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty result with nonzero corners");

    a_empty_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> r_mode == aabb_pkg::MODE_INTERSECT)
        else $error("empty flag raised in difference mode");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_valid && r5_sort |->
            r5_lo[0] <= r5_hi[0] && r5_lo[1] <= r5_hi[1] && r5_lo[2] <= r5_hi[2])
        else $error("built box has unordered corners");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input held off without an output stall");

endmodule

`default_nettype wire

[sim/aabb_intersect_difference_core_test.sv]
// Self-checking testbench for the box intersection and difference core.
// Depends on aabb_pkg and aabb_intersect_difference_core; predicts each result box
// at acceptance and compares it with the output stream under random idling.
`timescale 1ns / 1ps

module aabb_intersect_difference_core_test;

    localparam int CW = 32;
    localparam int ONE = 65536;
    localparam int COORD_MAX = 32'h7FFF_FFFF;
    localparam int COORD_MIN = 32'h8000_0000;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_NS = 1_000_000;
    localparam int TOL_W = aabb_pkg::TOL_BITS;
    localparam int CFG_IW = aabb_pkg::CFG_IDX_BITS;
    localparam int CFG_DW = aabb_pkg::CFG_DATA_BITS;
    localparam logic [CFG_IW-1:0] CFG_IDX_SPARE = 2'd3;

    typedef logic signed [CW-1:0] t_coord;

    // Packed so that the layout matches tdata: x lowest, low corners below high corners.
    typedef struct packed {
        t_coord [2:0] hi;
        t_coord [2:0] lo;
    } t_box;

    typedef struct packed {
        t_box b;
        t_box a;
    } t_pair;

    typedef struct packed {
        logic empty;
        t_box box;
    } t_box_result;

    logic clk;
    logic rst_n = 1'b0;
    t_pair cur_pair = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [6*CW-1:0] m_data;
    logic m_user;
    logic m_valid;
    logic m_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_idx = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    aabb_pkg::t_mode mode_mirror = aabb_pkg::MODE_INTERSECT;
    logic [TOL_W-1:0] tol_mirror = '0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    t_pair pending_pairs[$];
    t_box_result expected_boxes[$];

    aabb_intersect_difference_core #(.COORD_BITS(CW)) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tdata  (cur_pair),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Interval test in six ordered cases; touching intervals do not overlap.
    function automatic logic span_overlap(input int alo, input int ahi, input int blo,
                                          input int bhi, output int rlo, output int rhi);
        rlo = 0;
        rhi = 0;
        if (blo <= alo && bhi <= alo) return 1'b0;
        if (ahi <= blo && ahi <= bhi) return 1'b0;
        if (alo <= blo && bhi <= ahi) begin
            rlo = blo;
            rhi = bhi;
            return 1'b1;
        end
        if (blo <= alo && ahi <= bhi) begin
            rlo = alo;
            rhi = ahi;
            return 1'b1;
        end
        if (alo <= blo && ahi <= bhi) begin
            rlo = blo;
            rhi = ahi;
            return 1'b1;
        end
        if (blo <= alo && bhi <= ahi) begin
            rlo = alo;
            rhi = bhi;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic span_matches(input int alo, input int ahi, input int ilo,
                                          input int ihi, input longint tol);
        longint d;
        d = (longint'(ihi) - longint'(ilo)) - (longint'(ahi) - longint'(alo));
        return (d >= -tol) && (d <= tol);
    endfunction

    // Cuts the overlap off one end of A unless it sits inside A by more than tol at both ends.
    function automatic void trim_span(inout int alo, inout int ahi, input int ilo,
                                      input int ihi, input longint tol);
        logic split;
        split = (longint'(ilo) - longint'(alo) > tol) && (longint'(ahi) - longint'(ihi) > tol);
        if (!split) begin
            if (alo < ilo) begin
                ahi = ilo;
            end else if (ihi < ahi) begin
                alo = ihi;
            end
        end
    endfunction

    function automatic t_box_result box_op_result(input t_pair p, input aabb_pkg::t_mode mode,
                                                  input logic [TOL_W-1:0] tol);
        int alo[3], ahi[3], blo[3], bhi[3], slo[3], shi[3];
        logic hit, ox, oy, oz;
        longint t;
        t_box_result r;
        hit = 1'b1;
        r = '0;
        t = longint'(tol);
        for (int k = 0; k < 3; k++) begin
            alo[k] = p.a.lo[k];
            ahi[k] = p.a.hi[k];
            blo[k] = p.b.lo[k];
            bhi[k] = p.b.hi[k];
            slo[k] = 0;
            shi[k] = 0;
        end
        for (int k = 0; k < 3; k++) begin
            if (hit) hit = span_overlap(alo[k], ahi[k], blo[k], bhi[k], slo[k], shi[k]);
        end
        if (mode == aabb_pkg::MODE_INTERSECT) begin
            if (!hit) begin
                r.empty = 1'b1;
                return r;
            end
        end else if (!hit) begin
            // Disjoint boxes leave A untouched, corner order included.
            for (int k = 0; k < 3; k++) begin
                r.box.lo[k] = alo[k];
                r.box.hi[k] = ahi[k];
            end
            return r;
        end else begin
            ox = span_matches(alo[0], ahi[0], slo[0], shi[0], t);
            oy = span_matches(alo[1], ahi[1], slo[1], shi[1], t);
            oz = span_matches(alo[2], ahi[2], slo[2], shi[2], t);
            if (ox && oy) trim_span(alo[2], ahi[2], slo[2], shi[2], t);
            if (ox && oz) trim_span(alo[1], ahi[1], slo[1], shi[1], t);
            if (oy && oz) trim_span(alo[0], ahi[0], slo[0], shi[0], t);
            for (int k = 0; k < 3; k++) begin
                slo[k] = alo[k];
                shi[k] = ahi[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            r.box.lo[k] = (shi[k] < slo[k]) ? shi[k] : slo[k];
            r.box.hi[k] = (shi[k] < slo[k]) ? slo[k] : shi[k];
        end
        return r;
    endfunction

    function automatic int clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return int'(v);
    endfunction

    function automatic t_pair cube_pair(input int alo, input int ahi, input int blo,
                                        input int bhi);
        t_pair p;
        for (int k = 0; k < 3; k++) begin
            p.a.lo[k] = alo;
            p.a.hi[k] = ahi;
            p.b.lo[k] = blo;
            p.b.hi[k] = bhi;
        end
        return p;
    endfunction

    // One axis of a shaped pair: kind picks how B sits against A.
    function automatic void shape_axis(input int kind, input int unsigned jit, output int alo,
                                       output int ahi, output int blo, output int bhi);
        longint c, w, r, j0, j1, la, ha, lb, hb, tmp;
        w = longint'($urandom_range(1 << $urandom_range(24), 1));
        case ($urandom_range(4))
            0: c = longint'(int'($urandom));
            1: c = longint'(COORD_MAX) - w / 2;
            2: c = longint'(COORD_MIN) - w / 2;
            default: c = longint'($urandom_range(2000000)) - 1000000;
        endcase
        r = longint'($urandom_range(int'(w)));
        j0 = longint'($urandom_range(jit));
        j1 = longint'($urandom_range(jit));
        if ($urandom_range(1) == 1) j0 = -j0;
        if ($urandom_range(1) == 1) j1 = -j1;
        la = c;
        ha = c + w;
        case (kind)
            0: begin
                lb = la + j0;
                hb = ha + j1;
            end
            1: begin
                lb = la - r;
                hb = ha + r;
            end
            2: begin
                lb = la + w / 4;
                hb = ha - w / 4;
            end
            3: begin
                lb = la - r;
                hb = la + w / 2;
            end
            4: begin
                lb = la + w / 2;
                hb = ha + r;
            end
            5: begin
                lb = ha + r + 1;
                hb = lb + w;
            end
            6: begin
                if ($urandom_range(1) == 1) begin
                    lb = ha;
                    hb = ha + w;
                end else begin
                    lb = la - w;
                    hb = la;
                end
            end
            default: begin
                lb = c - w + longint'($urandom_range(3 * int'(w)));
                hb = lb + r;
            end
        endcase
        if ($urandom_range(15) == 0) begin
            tmp = la;
            la = ha;
            ha = tmp;
        end
        if ($urandom_range(15) == 0) begin
            tmp = lb;
            lb = hb;
            hb = tmp;
        end
        alo = clamp_coord(la);
        ahi = clamp_coord(ha);
        blo = clamp_coord(lb);
        bhi = clamp_coord(hb);
    endfunction

    // Mostly pairs that overlap fully on two axes so that the trim logic is reached,
    // with a share of plain random pairs as noise.
    function automatic t_pair random_pair(input int unsigned jit);
        t_pair p;
        int trim_axis, kind, alo, ahi, blo, bhi;
        if ($urandom_range(9) == 0) begin
            for (int k = 0; k < 3; k++) begin
                p.a.lo[k] = $urandom;
                p.a.hi[k] = $urandom;
                p.b.lo[k] = $urandom;
                p.b.hi[k] = $urandom;
            end
            return p;
        end
        trim_axis = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
            if (k == trim_axis || $urandom_range(4) == 0) begin
                kind = $urandom_range(7);
            end else begin
                kind = $urandom_range(1);
            end
            shape_axis(kind, jit, alo, ahi, blo, bhi);
            p.a.lo[k] = alo;
            p.a.hi[k] = ahi;
            p.b.lo[k] = blo;
            p.b.hi[k] = bhi;
        end
        return p;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Sender: the prediction is taken when the item is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_boxes.push_back(box_op_result(cur_pair, mode_mirror, tol_mirror));
            end
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_pair <= pending_pairs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_box_result want;
        t_box got;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("result box arrived with no item outstanding");
                    error_count++;
                end else begin
                    want = expected_boxes.pop_front();
                    got = m_data;
                    compare_field("empty_res", longint'(want.empty), longint'(m_user));
                    for (int k = 0; k < 3; k++) begin
                        compare_field($sformatf("r_%c_lo", "x" + k),
                                      longint'($signed(want.box.lo[k])),
                                      longint'($signed(got.lo[k])));
                        compare_field($sformatf("r_%c_hi", "x" + k),
                                      longint'($signed(want.box.hi[k])),
                                      longint'($signed(got.hi[k])));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx,
                             input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == aabb_pkg::CFG_MODE) begin
            mode_mirror = aabb_pkg::t_mode'(val[0]);
        end else if (idx == aabb_pkg::CFG_TOL) begin
            tol_mirror = val[TOL_W-1:0];
        end
    endtask

    // Holds the stimulus until every outstanding result has been seen. The queues
    // are looked at on the falling edge, after the rising-edge updates settle.
    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_valid || expected_boxes.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input aabb_pkg::t_mode mode, input logic [TOL_W-1:0] tol,
                              input int unsigned jit, input int idle_pct, input int stall_pct);
        write_reg(aabb_pkg::CFG_MODE, CFG_DW'(mode));
        write_reg(aabb_pkg::CFG_TOL, tol);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (ITEMS_PER_PHASE) pending_pairs.push_back(random_pair(jit));
        wait_idle();
    endtask

    initial begin : stimulus
        t_pair p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Intersection corner cases.
        write_reg(aabb_pkg::CFG_MODE, CFG_DW'(aabb_pkg::MODE_INTERSECT));
        write_reg(aabb_pkg::CFG_TOL, '0);
        pending_pairs.push_back(cube_pair(0, ONE, 0, ONE));
        pending_pairs.push_back(cube_pair(0, 4 * ONE, ONE, 2 * ONE));
        pending_pairs.push_back(cube_pair(ONE, 2 * ONE, 0, 4 * ONE));
        pending_pairs.push_back(cube_pair(0, 2 * ONE, ONE, 3 * ONE));
        pending_pairs.push_back(cube_pair(ONE, 3 * ONE, 0, 2 * ONE));
        pending_pairs.push_back(cube_pair(0, ONE, ONE, 2 * ONE));
        p = cube_pair(0, ONE, 0, ONE);
        p.b.lo[0] = 5 * ONE;
        p.b.hi[0] = 6 * ONE;
        pending_pairs.push_back(p);
        pending_pairs.push_back(cube_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        pending_pairs.push_back(cube_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        pending_pairs.push_back(cube_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        // B given high corner first; the overlap comes back ordered.
        pending_pairs.push_back(cube_pair(0, 4 * ONE, 3 * ONE, ONE));
        pending_pairs.push_back(cube_pair(COORD_MIN, COORD_MAX, -ONE, ONE));
        wait_idle();

        // Difference corner cases with exact tolerance.
        write_reg(aabb_pkg::CFG_MODE, CFG_DW'(aabb_pkg::MODE_DIFF));
        p = cube_pair(0, ONE, 0, ONE);
        p.a.lo[0] = ONE;
        p.a.hi[0] = 0;
        pending_pairs.push_back(p);
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[2] = 2 * ONE;
        p.b.hi[2] = 6 * ONE;
        pending_pairs.push_back(p);
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[2] = -2 * ONE;
        p.b.hi[2] = ONE;
        pending_pairs.push_back(p);
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[2] = ONE;
        p.b.hi[2] = 2 * ONE;
        pending_pairs.push_back(p);
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[1] = 2 * ONE;
        p.b.hi[1] = 6 * ONE;
        pending_pairs.push_back(p);
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[0] = -ONE;
        p.b.hi[0] = ONE;
        pending_pairs.push_back(p);
        pending_pairs.push_back(cube_pair(0, ONE, -ONE, 2 * ONE));
        p = cube_pair(0, 4 * ONE, 0, 4 * ONE);
        p.b.lo[0] = 2 * ONE;
        p.b.hi[0] = 6 * ONE;
        p.b.lo[1] = 2 * ONE;
        p.b.hi[1] = 6 * ONE;
        pending_pairs.push_back(p);
        pending_pairs.push_back(cube_pair(COORD_MIN, COORD_MAX, COORD_MIN, 0));
        wait_idle();

        // The widest tolerance turns a split into a trim.
        write_reg(aabb_pkg::CFG_TOL, {TOL_W{1'b1}});
        pending_pairs.push_back(cube_pair(0, 4 * ONE, ONE, 3 * ONE));
        wait_idle();

        // A write to an unused index must leave mode and tolerance alone.
        write_reg(CFG_IDX_SPARE, '1);
        pending_pairs.push_back(cube_pair(0, 4 * ONE, 2 * ONE, 6 * ONE));
        wait_idle();

        run_random(aabb_pkg::MODE_INTERSECT, '0, 4, 0, 0);
        run_random(aabb_pkg::MODE_DIFF, '0, 2, 46, 0);
        run_random(aabb_pkg::MODE_DIFF, {TOL_W{1'b1}}, 1 << 16, 0, 46);
        run_random(aabb_pkg::MODE_DIFF, TOL_W'(ONE), 1 << 17, 30, 30);
        run_random(aabb_pkg::MODE_INTERSECT, TOL_W'($urandom), 8, 30, 30);
        run_random(aabb_pkg::MODE_DIFF, TOL_W'($urandom_range(1 << 20)), 1 << 20, 46, 0);
        run_random(aabb_pkg::MODE_DIFF, TOL_W'(1), 2, 0, 46);
        run_random(aabb_pkg::MODE_DIFF, {TOL_W{1'b1}}, 1 << 24, 0, 0);

        if (expected_boxes.size() != 0) begin
            $error("%0d result boxes never arrived", expected_boxes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
